// File: rtl/spilb_pkg.sv
package spilb_pkg;

   // Register window geometry.
   localparam int WINDOW_BYTES = 40;
   localparam int NUM_REGS     = 10;
   localparam int ACCESS_LANES = 4;
   localparam int DATA_W       = 8 * ACCESS_LANES;
   localparam int ADDR_W       = 7;
   localparam int SLOT_W       = 4;
   localparam int COUNT_W      = 3;

   // Register slots, one every four bytes.
   localparam logic [SLOT_W-1:0] SLOT_CTRL1   = 4'd0;
   localparam logic [SLOT_W-1:0] SLOT_CTRL2   = 4'd1;
   localparam logic [SLOT_W-1:0] SLOT_STATUS  = 4'd2;
   localparam logic [SLOT_W-1:0] SLOT_DATA    = 4'd3;
   localparam logic [SLOT_W-1:0] SLOT_CRCPOLY = 4'd4;
   localparam logic [SLOT_W-1:0] SLOT_RXCRC   = 4'd5;
   localparam logic [SLOT_W-1:0] SLOT_TXCRC   = 4'd6;
   localparam logic [SLOT_W-1:0] SLOT_AUDCFG  = 4'd7;
   localparam logic [SLOT_W-1:0] SLOT_AUDPR   = 4'd8;
   localparam logic [SLOT_W-1:0] SLOT_HSCTL   = 4'd9;

   // Status bits.
   localparam int RXNE_POS = 0;
   localparam int TXE_POS  = 1;

   localparam logic [15:0] CRCPOLY_RESET = 16'h0007;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // One byte lane of an access after address decode.
   typedef struct packed {
      logic              live;
      logic [SLOT_W-1:0] slot;
      logic              hi;
   } lane_type;

endpackage

// File: rtl/spilb_decode.sv
module spilb_decode (
   input  logic [5:0]                                      byte_offset,
   input  logic [spilb_pkg::COUNT_W-1:0]                   access_bytes,
   output spilb_pkg::lane_type [spilb_pkg::ACCESS_LANES-1:0] lanes
);

   logic [spilb_pkg::ADDR_W-1:0] addr [spilb_pkg::ACCESS_LANES];

   // Each lane is live when it lies inside the length, inside the window and in the
   // low half of its slot.
   always_comb begin
      for (int i = 0; i < spilb_pkg::ACCESS_LANES; i++) begin
         addr[i] = {1'b0, byte_offset} + spilb_pkg::ADDR_W'(i);
         lanes[i].live = (spilb_pkg::COUNT_W'(i) < access_bytes)
            && (addr[i] < spilb_pkg::ADDR_W'(spilb_pkg::WINDOW_BYTES))
            && !addr[i][1]
            && (addr[i][spilb_pkg::ADDR_W-1:2] < 5'(spilb_pkg::NUM_REGS));
         lanes[i].slot = addr[i][spilb_pkg::SLOT_W+1:2];
         lanes[i].hi   = addr[i][0];
      end
   end

endmodule

// File: rtl/spilb_regs.sv
module spilb_regs (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              update,
   input  logic                                              cmd,
   input  spilb_pkg::lane_type [spilb_pkg::ACCESS_LANES-1:0] lanes,
   input  logic [spilb_pkg::DATA_W-1:0]                      write_data,
   output logic [spilb_pkg::DATA_W-1:0]                      read_data
);

   logic [15:0] ctrl1_ff, ctrl1_in;
   logic [15:0] ctrl2_ff, ctrl2_in;
   logic [15:0] holding_ff, holding_in;
   logic        rxne_ff, rxne_in;
   logic [15:0] crcpoly_ff, crcpoly_in;
   logic [15:0] rxcrc_ff, rxcrc_in;
   logic [15:0] txcrc_ff, txcrc_in;
   logic [15:0] audcfg_ff, audcfg_in;
   logic [15:0] audpr_ff, audpr_in;
   logic [15:0] hsctl_ff, hsctl_in;

   logic [15:0] status_view;
   logic [15:0] lane_word [spilb_pkg::ACCESS_LANES];
   logic        wr_lo [spilb_pkg::NUM_REGS];
   logic        wr_hi [spilb_pkg::NUM_REGS];
   logic [7:0]  lo_byte [spilb_pkg::NUM_REGS];
   logic [7:0]  hi_byte [spilb_pkg::NUM_REGS];
   logic        touch_data;

   function automatic logic [15:0] merge(input logic [15:0] old, input logic en_lo,
                                         input logic en_hi, input logic [7:0] lo,
                                         input logic [7:0] hi);
      logic [15:0] v;
      v = old;
      if (en_lo) begin
         v[7:0] = lo;
      end
      if (en_hi) begin
         v[15:8] = hi;
      end
      return v;
   endfunction

   // The stored status only ever differs from its reset value in the receive-full
   // bit, and busy is never set, so the status view is built from the flag alone.
   always_comb begin
      status_view = '0;
      status_view[spilb_pkg::TXE_POS]  = 1'b1;
      status_view[spilb_pkg::RXNE_POS] = rxne_ff;
   end

   // Read path: one slot select per byte lane.
   always_comb begin
      read_data = '0;
      for (int i = 0; i < spilb_pkg::ACCESS_LANES; i++) begin
         case (lanes[i].slot)
            spilb_pkg::SLOT_CTRL1:   lane_word[i] = ctrl1_ff;
            spilb_pkg::SLOT_CTRL2:   lane_word[i] = ctrl2_ff;
            spilb_pkg::SLOT_STATUS:  lane_word[i] = status_view;
            spilb_pkg::SLOT_DATA:    lane_word[i] = holding_ff;
            spilb_pkg::SLOT_CRCPOLY: lane_word[i] = crcpoly_ff;
            spilb_pkg::SLOT_RXCRC:   lane_word[i] = rxcrc_ff;
            spilb_pkg::SLOT_TXCRC:   lane_word[i] = txcrc_ff;
            spilb_pkg::SLOT_AUDCFG:  lane_word[i] = audcfg_ff;
            spilb_pkg::SLOT_AUDPR:   lane_word[i] = audpr_ff;
            spilb_pkg::SLOT_HSCTL:   lane_word[i] = hsctl_ff;
            default:                 lane_word[i] = '0;
         endcase
         if (lanes[i].live) begin
            read_data[8*i +: 8] = lanes[i].hi ? lane_word[i][15:8] : lane_word[i][7:0];
         end
      end
   end

   // Byte write enables per register. Addresses in one access are distinct, so at
   // most one lane hits any register byte.
   always_comb begin
      touch_data = 1'b0;
      for (int s = 0; s < spilb_pkg::NUM_REGS; s++) begin
         wr_lo[s]   = 1'b0;
         wr_hi[s]   = 1'b0;
         lo_byte[s] = '0;
         hi_byte[s] = '0;
         for (int i = 0; i < spilb_pkg::ACCESS_LANES; i++) begin
            if (lanes[i].live && (lanes[i].slot == spilb_pkg::SLOT_W'(s))) begin
               if (lanes[i].hi) begin
                  wr_hi[s]   = update && (cmd == spilb_pkg::CMD_WRITE);
                  hi_byte[s] = write_data[8*i +: 8];
               end else begin
                  wr_lo[s]   = update && (cmd == spilb_pkg::CMD_WRITE);
                  lo_byte[s] = write_data[8*i +: 8];
               end
            end
         end
      end
      for (int i = 0; i < spilb_pkg::ACCESS_LANES; i++) begin
         if (lanes[i].live && (lanes[i].slot == spilb_pkg::SLOT_DATA)) begin
            touch_data = 1'b1;
         end
      end
   end

   always_comb begin
      ctrl1_in   = merge(ctrl1_ff, wr_lo[spilb_pkg::SLOT_CTRL1], wr_hi[spilb_pkg::SLOT_CTRL1],
                         lo_byte[spilb_pkg::SLOT_CTRL1], hi_byte[spilb_pkg::SLOT_CTRL1]);
      ctrl2_in   = merge(ctrl2_ff, wr_lo[spilb_pkg::SLOT_CTRL2], wr_hi[spilb_pkg::SLOT_CTRL2],
                         lo_byte[spilb_pkg::SLOT_CTRL2], hi_byte[spilb_pkg::SLOT_CTRL2]);
      holding_in = merge(holding_ff, wr_lo[spilb_pkg::SLOT_DATA], wr_hi[spilb_pkg::SLOT_DATA],
                         lo_byte[spilb_pkg::SLOT_DATA], hi_byte[spilb_pkg::SLOT_DATA]);
      crcpoly_in = merge(crcpoly_ff, wr_lo[spilb_pkg::SLOT_CRCPOLY],
                         wr_hi[spilb_pkg::SLOT_CRCPOLY], lo_byte[spilb_pkg::SLOT_CRCPOLY],
                         hi_byte[spilb_pkg::SLOT_CRCPOLY]);
      rxcrc_in   = merge(rxcrc_ff, wr_lo[spilb_pkg::SLOT_RXCRC], wr_hi[spilb_pkg::SLOT_RXCRC],
                         lo_byte[spilb_pkg::SLOT_RXCRC], hi_byte[spilb_pkg::SLOT_RXCRC]);
      txcrc_in   = merge(txcrc_ff, wr_lo[spilb_pkg::SLOT_TXCRC], wr_hi[spilb_pkg::SLOT_TXCRC],
                         lo_byte[spilb_pkg::SLOT_TXCRC], hi_byte[spilb_pkg::SLOT_TXCRC]);
      audcfg_in  = merge(audcfg_ff, wr_lo[spilb_pkg::SLOT_AUDCFG], wr_hi[spilb_pkg::SLOT_AUDCFG],
                         lo_byte[spilb_pkg::SLOT_AUDCFG], hi_byte[spilb_pkg::SLOT_AUDCFG]);
      audpr_in   = merge(audpr_ff, wr_lo[spilb_pkg::SLOT_AUDPR], wr_hi[spilb_pkg::SLOT_AUDPR],
                         lo_byte[spilb_pkg::SLOT_AUDPR], hi_byte[spilb_pkg::SLOT_AUDPR]);
      hsctl_in   = merge(hsctl_ff, wr_lo[spilb_pkg::SLOT_HSCTL], wr_hi[spilb_pkg::SLOT_HSCTL],
                         lo_byte[spilb_pkg::SLOT_HSCTL], hi_byte[spilb_pkg::SLOT_HSCTL]);

      // Bytes go in ascending order and status sits below data, so a data write
      // always wins over a status clear in the same access.
      rxne_in = rxne_ff;
      if (update) begin
         if (cmd == spilb_pkg::CMD_WRITE) begin
            if (wr_lo[spilb_pkg::SLOT_STATUS]
                && !lo_byte[spilb_pkg::SLOT_STATUS][spilb_pkg::RXNE_POS]) begin
               rxne_in = 1'b0;
            end
            if (wr_lo[spilb_pkg::SLOT_DATA] || wr_hi[spilb_pkg::SLOT_DATA]) begin
               rxne_in = 1'b1;
            end
         end else if (touch_data) begin
            rxne_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff   <= '0;
         ctrl2_ff   <= '0;
         holding_ff <= '0;
         rxne_ff    <= 1'b0;
         crcpoly_ff <= spilb_pkg::CRCPOLY_RESET;
         rxcrc_ff   <= '0;
         txcrc_ff   <= '0;
         audcfg_ff  <= '0;
         audpr_ff   <= '0;
         hsctl_ff   <= '0;
      end else begin
         ctrl1_ff   <= ctrl1_in;
         ctrl2_ff   <= ctrl2_in;
         holding_ff <= holding_in;
         rxne_ff    <= rxne_in;
         crcpoly_ff <= crcpoly_in;
         rxcrc_ff   <= rxcrc_in;
         txcrc_ff   <= txcrc_in;
         audcfg_ff  <= audcfg_in;
         audpr_ff   <= audpr_in;
         hsctl_ff   <= hsctl_in;
      end
   end

   a_data_write_sets_flag: assert property (@(posedge clock) disable iff (reset)
      (wr_lo[spilb_pkg::SLOT_DATA] || wr_hi[spilb_pkg::SLOT_DATA]) |=> rxne_ff)
      else $error("data write did not set receive-full");

   a_data_read_clears_flag: assert property (@(posedge clock) disable iff (reset)
      (update && (cmd == spilb_pkg::CMD_READ) && touch_data) |=> !rxne_ff)
      else $error("data read did not clear receive-full");

   a_no_change_without_update: assert property (@(posedge clock) disable iff (reset)
      !update |=> $stable(rxne_ff) && $stable(holding_ff) && $stable(ctrl1_ff))
      else $error("register changed without an access");

endmodule

// File: rtl/spi_loopback_register_bank.sv
// Loopback serial-port register bank with ten 16-bit registers on a 40-byte window.
// Each request transfer carries one bus access: req_cmd selects read or write,
// req_byte_offset the first byte, req_access_bytes the length (1 to 4, larger values
// act as 4) and req_write_data the write bytes in little-endian lanes. Every request
// produces exactly one response transfer on rsp_read_data; writes return zero, and
// reserved or out-of-window bytes read as zero.
// The request is first captured in an input register; once the response register is
// empty or being drained, the access decodes the byte lanes, reads and updates the
// registers and loads the response register, which then offers the response.
// One access is accepted every cycle as long as the response side keeps up.
// When the receiver stalls, the pending response holds in its register and the
// input register still takes one more request; req_ready drops only when both are
// full and rsp_ready is low. The rate is set by this two-register pipeline.
// A synchronous reset empties both stages and returns every register to its reset
// value: control, CRC and audio registers to zero, the CRC polynomial to 0x0007,
// the data holding register to zero and the receive-full flag cleared.
module spi_loopback_register_bank (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [5:0]                          req_byte_offset,
   input  logic [spilb_pkg::COUNT_W-1:0]       req_access_bytes,
   input  logic [spilb_pkg::DATA_W-1:0]        req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [spilb_pkg::DATA_W-1:0]        rsp_read_data
);

   // Input stage.
   logic                           in_valid_ff, in_valid_in;
   logic                           cmd_ff;
   logic [5:0]                     offset_ff;
   logic [spilb_pkg::COUNT_W-1:0]  bytes_ff;
   logic [spilb_pkg::DATA_W-1:0]   wdata_ff;

   // Response stage.
   logic                           out_valid_ff, out_valid_in;
   logic [spilb_pkg::DATA_W-1:0]   out_data_ff;

   logic                           advance;
   logic                           req_take;
   logic [spilb_pkg::DATA_W-1:0]   bank_rdata;
   spilb_pkg::lane_type [spilb_pkg::ACCESS_LANES-1:0] lanes;

   // The held access moves on when the response register is empty or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   spilb_decode u_decode (
      .byte_offset  (offset_ff),
      .access_bytes (bytes_ff),
      .lanes        (lanes)
   );

   spilb_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .update     (advance),
      .cmd        (cmd_ff),
      .lanes      (lanes),
      .write_data (wdata_ff),
      .read_data  (bank_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff    <= req_cmd;
         offset_ff <= req_byte_offset;
         bytes_ff  <= req_access_bytes;
         wdata_ff  <= req_write_data;
      end
      // Writes always answer with zero data.
      if (advance) begin
         out_data_ff <= (cmd_ff == spilb_pkg::CMD_WRITE) ? '0 : bank_rdata;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_data_ff;

   a_ready_low_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("request side stalled while the pipeline had room");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced access produced no response");

   a_take_fills_input: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted request was lost from the input stage");

endmodule
